// ===== src/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = 9;
    localparam int DATA_W = 16;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_BACK  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -16'sd1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

endpackage

// ===== src/deq_if.sv =====
`timescale 1ns / 1ps

interface deq_cmd_if;
    logic                      valid;
    logic                      ready;
    deq_pkg::t_opcode          opcode;
    logic signed [15:0]        push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic signed [15:0]        pop_value;
    logic                      empty_error;
    logic                      full_drop;
    logic [8:0]                occupancy;

    modport source (output valid, output pop_value, output empty_error,
                    output full_drop, output occupancy, input ready);
    modport sink   (input valid, input pop_value, input empty_error,
                    input full_drop, input occupancy, output ready);
endinterface

// ===== src/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// double-ended queue of 16-bit signed values in a 256-entry ring memory.
// i_cmd carries one operation per transaction: opcode (push front, pop front,
// push back, pop back) and push_value. o_rsp returns one transaction per
// operation: pop_value, empty_error, full_drop and occupancy after the op.
// a push writes the ring in the cycle it is accepted; its response is valid
// the next cycle, and a new command can be taken every cycle while responses drain.
// a pop reads the ring into its read register r_rd_data; the read state then
// moves it to the response register, and the next command waits until then.
// a pop on an empty queue answers -1 with empty_error set the next cycle;
// a push on a full queue is dropped with full_drop set.
// the response sits in an output register; while the receiver stalls, a new
// command is taken only in the cycle that register is drained.
// reset (i_rst_n low, synchronous) empties the queue: front at 0, back one
// before it, count zero. ring contents are not cleared and need not be,
// since only written entries are ever popped.
module double_ended_queue_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_cmd_if.sink   i_cmd,
    deq_rsp_if.source o_rsp
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] r_ring [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_front, n_front;
    logic [PTR_W-1:0]   r_back, n_back;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_pop_value, n_pop_value;
    logic               r_empty_error, n_empty_error;
    logic               r_full_drop, n_full_drop;
    logic [CNT_W-1:0]   r_occupancy, n_occupancy;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               cmd_take;
    logic [PTR_W-1:0]   front_prev, front_next, back_prev, back_next;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    assign front_prev = (r_front == '0) ? PTR_LAST : r_front - 1'b1;
    assign front_next = (r_front == PTR_LAST) ? '0 : r_front + 1'b1;
    assign back_prev  = (r_back == '0) ? PTR_LAST : r_back - 1'b1;
    assign back_next  = (r_back == PTR_LAST) ? '0 : r_back + 1'b1;

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_back        = r_back;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_pop_value   = r_pop_value;
        n_empty_error = r_empty_error;
        n_full_drop   = r_full_drop;
        n_occupancy   = r_occupancy;
        wr_en         = 1'b0;
        wr_addr       = r_front;
        rd_en         = 1'b0;
        rd_addr       = r_front;

        case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    n_empty_error = 1'b0;
                    n_full_drop   = 1'b0;
                    n_pop_value   = '0;
                    case (i_cmd.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (r_count == CNT_FULL) begin
                                n_full_drop = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_cmd.opcode == OP_PUSH_FRONT) begin
                                    n_front = front_prev;
                                    wr_addr = front_prev;
                                end else begin
                                    n_back  = back_next;
                                    wr_addr = back_next;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_valid   = 1'b1;
                                n_empty_error = 1'b1;
                                n_pop_value   = EMPTY_VALUE;
                            end else begin
                                // value arrives from the ring next cycle
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_READ;
                                if (i_cmd.opcode == OP_POP_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = front_next;
                                end else begin
                                    rd_addr = r_back;
                                    n_back  = back_prev;
                                end
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_occupancy = n_count;
                end
            end
            S_READ: begin
                n_pop_value = r_rd_data;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= i_cmd.push_value;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= PTR_LAST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_value   <= n_pop_value;
        r_empty_error <= n_empty_error;
        r_full_drop   <= n_full_drop;
        r_occupancy   <= n_occupancy;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.pop_value   = r_pop_value;
    assign o_rsp.empty_error = r_empty_error;
    assign o_rsp.full_drop   = r_full_drop;
    assign o_rsp.occupancy   = r_occupancy;

endmodule
